// ===== sv/lru_page_replacement_assert.svh =====
// Assertion macros shared by the LRU page replacement checker.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define LRU_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("LRU assertion failed");

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define LRU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("LRU assertion failed");

`endif

// ===== sv/lru_pkg.sv =====
// Package with widths, reset values and shared types of the LRU page replacement block.
package lru_pkg;

   // Fixed port field widths.
   localparam int PAGE_WIDTH        = 8;
   localparam int FRAME_INDEX_WIDTH = 4;
   localparam int COUNT_WIDTH       = 16;
   localparam int FRAME_COUNT_WIDTH = 5;

   // Reset value of the frame count register.
   localparam logic [FRAME_COUNT_WIDTH-1:0] FRAME_COUNT_RESET = 5'd4;

   // Saturation limit of the run counters.
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   // Default build parameters.
   localparam int DEFAULT_MAX_FRAMES = 16;
   localparam int DEFAULT_PAGE_BITS  = 8;

   // What one access does to the frame table; exactly one bit is set.
   typedef struct packed {
      logic hit;
      logic fill;
      logic evict;
   } lru_action_type;

endpackage

// ===== sv/lru_page_replacement.sv =====
// Top level of the LRU page replacement engine.
//
//  Channel  Direction  Handshake            Carries
//  req      in         req_valid/req_ready  page, start_of_run
//  rsp      out        rsp_valid/rsp_ready  hit, frame_index, evicted page, counts
//  csr      in         csr_wr_en            frame_count (5 bits), no read-back
//
// One beat is taken per cycle while rsp_ready is high. A beat waits in the input register,
// where the combinational frame lookup and table update work on it, and then moves into
// the result register, from which it shows on rsp. That lookup and update between the
// input and result registers set this rate.
// Reset empties all frames, clears both counters and sets frame_count to 4.
// While rsp_ready is low the result register holds its beat, the input register
// takes one more beat, and req_ready then drops until the result is taken.
module lru_page_replacement #(
   parameter int MAX_FRAMES = lru_pkg::DEFAULT_MAX_FRAMES,
   parameter int PAGE_BITS  = lru_pkg::DEFAULT_PAGE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [lru_pkg::PAGE_WIDTH-1:0]         req_page,
   input  logic                                   req_start_of_run,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic                                   rsp_hit,
   output logic [lru_pkg::FRAME_INDEX_WIDTH-1:0]  rsp_frame_index,
   output logic                                   rsp_evicted_valid,
   output logic [lru_pkg::PAGE_WIDTH-1:0]         rsp_evicted_page,
   output logic [lru_pkg::COUNT_WIDTH-1:0]        rsp_fault_count,
   output logic [lru_pkg::COUNT_WIDTH-1:0]        rsp_access_count,
   input  logic                                   csr_wr_en,
   input  logic [lru_pkg::FRAME_COUNT_WIDTH-1:0]  csr_wr_data
);

   localparam int IDX_W  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int FILL_W = $clog2(MAX_FRAMES + 1);
   // Wide enough for both the frame count register and MAX_FRAMES.
   localparam int CMP_W  = 8;

   // Configuration register.
   logic [lru_pkg::FRAME_COUNT_WIDTH-1:0] frame_count_ff;
   logic [CMP_W-1:0]                      frame_count_wide;
   logic [FILL_W-1:0]                     frames_in_use;

   // Input register.
   logic                 s1_valid_ff;
   logic [PAGE_BITS-1:0] s1_page_ff;
   logic [PAGE_BITS-1:0] s1_page_in;
   logic                 s1_start_ff;
   logic [PAGE_BITS+lru_pkg::PAGE_WIDTH-1:0] page_ext;
   logic                 advance;

   // Frame table view and lookup result.
   logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] frame_valid;
   logic [IDX_W-1:0]      frame_rank [MAX_FRAMES];
   logic [FILL_W-1:0]     filled;
   lru_pkg::lru_action_type action;
   logic [IDX_W-1:0]      frame;
   logic [IDX_W-1:0]      hit_rank;
   logic [PAGE_BITS-1:0]  victim_page;

   // Run counters.
   logic [lru_pkg::COUNT_WIDTH-1:0] fault_ff;
   logic [lru_pkg::COUNT_WIDTH-1:0] fault_in;
   logic [lru_pkg::COUNT_WIDTH-1:0] access_ff;
   logic [lru_pkg::COUNT_WIDTH-1:0] access_in;
   logic [lru_pkg::COUNT_WIDTH-1:0] fault_base;
   logic [lru_pkg::COUNT_WIDTH-1:0] access_base;

   // Result register.
   logic                                  rsp_valid_ff;
   logic                                  rsp_hit_ff;
   logic [lru_pkg::FRAME_INDEX_WIDTH-1:0] rsp_frame_index_ff;
   logic [lru_pkg::FRAME_INDEX_WIDTH-1:0] rsp_frame_index_in;
   logic                                  rsp_evicted_valid_ff;
   logic [lru_pkg::PAGE_WIDTH-1:0]        rsp_evicted_page_ff;
   logic [lru_pkg::PAGE_WIDTH-1:0]        rsp_evicted_page_in;
   logic [lru_pkg::COUNT_WIDTH+IDX_W-1:0] frame_ext;
   logic [PAGE_BITS+lru_pkg::PAGE_WIDTH-1:0] victim_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= lru_pkg::FRAME_COUNT_RESET;
      end else if (csr_wr_en) begin
         frame_count_ff <= csr_wr_data;
      end
   end

   // A frame count of zero acts as one, and anything above the build limit as the limit.
   assign frame_count_wide = CMP_W'(frame_count_ff);
   always_comb begin
      if (frame_count_wide == '0) begin
         frames_in_use = FILL_W'(1);
      end else if (frame_count_wide > CMP_W'(MAX_FRAMES)) begin
         frames_in_use = FILL_W'(MAX_FRAMES);
      end else begin
         frames_in_use = frame_count_wide[FILL_W-1:0];
      end
   end

   // The result register frees up when it is empty or being read this cycle.
   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // Only the low PAGE_BITS bits of the page take part.
   assign page_ext   = {{PAGE_BITS{1'b0}}, req_page};
   assign s1_page_in = page_ext[PAGE_BITS-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_ready) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         s1_page_ff  <= s1_page_in;
         s1_start_ff <= req_start_of_run;
      end
   end

   lru_lookup #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .IDX_W      (IDX_W),
      .FILL_W     (FILL_W)
   ) u_lookup (
      .page          (s1_page_ff),
      .clear         (s1_start_ff),
      .frames_in_use (frames_in_use),
      .frame_page    (frame_page),
      .frame_valid   (frame_valid),
      .frame_rank    (frame_rank),
      .filled        (filled),
      .action        (action),
      .frame         (frame),
      .hit_rank      (hit_rank),
      .victim_page   (victim_page)
   );

   // The table changes exactly when the beat moves into the result register.
   lru_frame_table #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .IDX_W      (IDX_W),
      .FILL_W     (FILL_W)
   ) u_frame_table (
      .clock       (clock),
      .reset       (reset),
      .update      (advance),
      .clear       (s1_start_ff),
      .action      (action),
      .frame       (frame),
      .hit_rank    (hit_rank),
      .page        (s1_page_ff),
      .frame_page  (frame_page),
      .frame_valid (frame_valid),
      .frame_rank  (frame_rank),
      .filled      (filled)
   );

   // Counters restart with the access that opens a run and stop at their maximum.
   assign fault_base  = s1_start_ff ? '0 : fault_ff;
   assign access_base = s1_start_ff ? '0 : access_ff;
   assign fault_in    = (!action.hit && fault_base != lru_pkg::COUNT_MAX)
                        ? fault_base + 16'd1 : fault_base;
   assign access_in   = (access_base != lru_pkg::COUNT_MAX)
                        ? access_base + 16'd1 : access_base;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_ff  <= '0;
         access_ff <= '0;
      end else if (advance) begin
         fault_ff  <= fault_in;
         access_ff <= access_in;
      end
   end

   assign frame_ext           = {{lru_pkg::COUNT_WIDTH{1'b0}}, frame};
   assign rsp_frame_index_in  = frame_ext[lru_pkg::FRAME_INDEX_WIDTH-1:0];
   assign victim_ext          = {{lru_pkg::PAGE_WIDTH{1'b0}}, victim_page};
   assign rsp_evicted_page_in = action.evict ? victim_ext[lru_pkg::PAGE_WIDTH-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_hit_ff           <= action.hit;
         rsp_frame_index_ff   <= rsp_frame_index_in;
         rsp_evicted_valid_ff <= action.evict;
         rsp_evicted_page_ff  <= rsp_evicted_page_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_frame_index   = rsp_frame_index_ff;
   assign rsp_evicted_valid = rsp_evicted_valid_ff;
   assign rsp_evicted_page  = rsp_evicted_page_ff;
   assign rsp_fault_count   = fault_ff;
   assign rsp_access_count  = access_ff;

endmodule

// ===== sv/lru_lookup.sv =====
// Parallel frame lookup: hit search, free-frame fill and LRU victim selection.
module lru_lookup #(
   parameter int MAX_FRAMES = lru_pkg::DEFAULT_MAX_FRAMES,
   parameter int PAGE_BITS  = lru_pkg::DEFAULT_PAGE_BITS,
   parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   parameter int FILL_W     = $clog2(MAX_FRAMES + 1)
) (
   input  logic [PAGE_BITS-1:0]  page,
   input  logic                  clear,
   input  logic [FILL_W-1:0]     frames_in_use,
   input  logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES],
   input  logic [MAX_FRAMES-1:0] frame_valid,
   input  logic [IDX_W-1:0]      frame_rank [MAX_FRAMES],
   input  logic [FILL_W-1:0]     filled,
   output lru_pkg::lru_action_type action,
   output logic [IDX_W-1:0]      frame,
   output logic [IDX_W-1:0]      hit_rank,
   output logic [PAGE_BITS-1:0]  victim_page
);

   logic [FILL_W-1:0]     filled_eff;
   logic [FILL_W-1:0]     oldest_rank;
   logic [MAX_FRAMES-1:0] valid_eff;
   logic                  hit;
   logic [IDX_W-1:0]      hit_idx;
   logic [IDX_W-1:0]      victim_idx;

   // A start of run makes the table look empty for this access.
   assign filled_eff  = clear ? '0 : filled;
   assign valid_eff   = clear ? '0 : frame_valid;
   // Ranks of occupied frames are a permutation, so the oldest has rank filled-1.
   assign oldest_rank = filled_eff - FILL_W'(1);

   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      hit_rank   = '0;
      victim_idx = '0;
      victim_page = '0;
      // Descending scan so the lowest matching frame wins.
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (valid_eff[i] && frame_page[i] == page) begin
            hit      = 1'b1;
            hit_idx  = IDX_W'(i);
            hit_rank = frame_rank[i];
         end
         if (valid_eff[i] && FILL_W'(frame_rank[i]) == oldest_rank) begin
            victim_idx  = IDX_W'(i);
            victim_page = frame_page[i];
         end
      end
   end

   always_comb begin
      action.hit   = hit;
      action.fill  = !hit && (filled_eff < frames_in_use);
      action.evict = !hit && !(filled_eff < frames_in_use);
      if (action.hit) begin
         frame = hit_idx;
      end else if (action.fill) begin
         frame = filled_eff[IDX_W-1:0];
      end else begin
         frame = victim_idx;
      end
   end

endmodule

// ===== sv/lru_frame_table.sv =====
// Frame table registers: resident pages, valid bits, recency ranks and fill count.
module lru_frame_table #(
   parameter int MAX_FRAMES = lru_pkg::DEFAULT_MAX_FRAMES,
   parameter int PAGE_BITS  = lru_pkg::DEFAULT_PAGE_BITS,
   parameter int IDX_W      = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   parameter int FILL_W     = $clog2(MAX_FRAMES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  update,
   input  logic                  clear,
   input  lru_pkg::lru_action_type action,
   input  logic [IDX_W-1:0]      frame,
   input  logic [IDX_W-1:0]      hit_rank,
   input  logic [PAGE_BITS-1:0]  page,
   output logic [PAGE_BITS-1:0]  frame_page [MAX_FRAMES],
   output logic [MAX_FRAMES-1:0] frame_valid,
   output logic [IDX_W-1:0]      frame_rank [MAX_FRAMES],
   output logic [FILL_W-1:0]     filled
);

   logic [PAGE_BITS-1:0]  page_ff  [MAX_FRAMES];
   logic [PAGE_BITS-1:0]  page_in  [MAX_FRAMES];
   logic [IDX_W-1:0]      rank_ff  [MAX_FRAMES];
   logic [IDX_W-1:0]      rank_in  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [MAX_FRAMES-1:0] valid_in;
   logic [FILL_W-1:0]     filled_ff;
   logic [FILL_W-1:0]     filled_in;

   always_comb begin
      logic valid_base;
      logic is_frame;
      logic age;
      for (int i = 0; i < MAX_FRAMES; i++) begin
         valid_base = !clear && valid_ff[i];
         is_frame   = (frame == IDX_W'(i));
         // A hit ages only the frames that were newer than it; a miss ages them all.
         age        = valid_base && !is_frame && (!action.hit || rank_ff[i] < hit_rank);
         valid_in[i] = valid_base || (is_frame && action.fill);
         if (is_frame) begin
            rank_in[i] = '0;
         end else if (age) begin
            rank_in[i] = rank_ff[i] + IDX_W'(1);
         end else begin
            rank_in[i] = rank_ff[i];
         end
         page_in[i] = (is_frame && !action.hit) ? page : page_ff[i];
      end
      filled_in = (clear ? '0 : filled_ff) + FILL_W'(action.fill);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         filled_ff <= '0;
      end else if (update) begin
         valid_ff  <= valid_in;
         filled_ff <= filled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (update) begin
         page_ff <= page_in;
         rank_ff <= rank_in;
      end
   end

   assign frame_page  = page_ff;
   assign frame_valid = valid_ff;
   assign frame_rank  = rank_ff;
   assign filled      = filled_ff;

endmodule

// ===== sv/lru_checker.sv =====
// Port-level assertion checker for the LRU page replacement engine, with its bind.
`include "lru_page_replacement_assert.svh"

module lru_checker (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic                                   rsp_hit,
   input logic [lru_pkg::FRAME_INDEX_WIDTH-1:0]  rsp_frame_index,
   input logic                                   rsp_evicted_valid,
   input logic [lru_pkg::PAGE_WIDTH-1:0]         rsp_evicted_page,
   input logic [lru_pkg::COUNT_WIDTH-1:0]        rsp_fault_count,
   input logic [lru_pkg::COUNT_WIDTH-1:0]        rsp_access_count
);

   localparam int RSP_W = 2 + lru_pkg::FRAME_INDEX_WIDTH + lru_pkg::PAGE_WIDTH
                          + 2 * lru_pkg::COUNT_WIDTH;

   // The whole result beat, so that a stall can be checked in one go.
   logic [RSP_W-1:0] rsp_payload;

   assign rsp_payload = {rsp_hit, rsp_frame_index, rsp_evicted_valid, rsp_evicted_page,
                         rsp_fault_count, rsp_access_count};

   // A stalled result beat stays put.
   `LRU_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))
   // A hit never evicts anything.
   `LRU_ASSERT_IMPLY(a_hit_no_evict, rsp_valid && rsp_hit, !rsp_evicted_valid)
   // The evicted page field reads zero when nothing was evicted.
   `LRU_ASSERT_IMPLY(a_evict_zero, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)
   // Every fault is also an access, so faults never outnumber accesses.
   `LRU_ASSERT_IMPLY(a_count_order, rsp_valid, rsp_fault_count <= rsp_access_count)

endmodule

bind lru_page_replacement lru_checker u_lru_checker (.*);

// ===== dv/tb_top.sv =====
// Self-checking testbench for the LRU page replacement engine.
module tb_top;

   // Field widths as the block uses them.
   localparam int PAGE_WIDTH        = lru_pkg::PAGE_WIDTH;
   localparam int FRAME_INDEX_WIDTH = lru_pkg::FRAME_INDEX_WIDTH;
   localparam int COUNT_WIDTH       = lru_pkg::COUNT_WIDTH;
   localparam int FRAME_COUNT_WIDTH = lru_pkg::FRAME_COUNT_WIDTH;

   // The block is built with its default sizes, so the predictor uses the same ones.
   localparam int FRAMES     = lru_pkg::DEFAULT_MAX_FRAMES;
   localparam int CYCLE_CAP  = 1000000;
   localparam int NO_WRITE   = -1;
   localparam int PHASE_BEATS = 340;
   localparam int CSR_EVERY   = 85;

   // One result beat, field for field as it leaves the block.
   typedef struct packed {
      logic                         hit;
      logic [FRAME_INDEX_WIDTH-1:0] frame_index;
      logic                         evicted_valid;
      logic [PAGE_WIDTH-1:0]        evicted_page;
      logic [COUNT_WIDTH-1:0]       fault_count;
      logic [COUNT_WIDTH-1:0]       access_count;
   } access_result_type;

   // One line of the directed table. A frame count write, when asked for, happens
   // with the block idle just before the access goes out.
   typedef struct {
      int                    csr_value;
      logic [PAGE_WIDTH-1:0] page;
      logic                  start;
      bit                    typed;
      access_result_type     outcome;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [PAGE_WIDTH-1:0] req_page = '0;
   logic req_start_of_run = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b1;
   logic rsp_hit;
   logic [FRAME_INDEX_WIDTH-1:0] rsp_frame_index;
   logic rsp_evicted_valid;
   logic [PAGE_WIDTH-1:0] rsp_evicted_page;
   logic [COUNT_WIDTH-1:0] rsp_fault_count;
   logic [COUNT_WIDTH-1:0] rsp_access_count;
   logic csr_wr_en = 1'b0;
   logic [FRAME_COUNT_WIDTH-1:0] csr_wr_data = '0;

   // Predictor state: a private copy of the frame table, its recency order,
   // the run counters and the frame count register.
   logic [PAGE_WIDTH-1:0]        tbl_page[FRAMES];
   logic                         tbl_valid[FRAMES];
   logic [3:0]                   tbl_rank[FRAMES];
   logic [4:0]                   tbl_filled;
   logic [COUNT_WIDTH-1:0]       run_faults;
   logic [COUNT_WIDTH-1:0]       run_accesses;
   logic [FRAME_COUNT_WIDTH-1:0] frame_count_reg;

   // Lookup outcomes still owed by the block, oldest first.
   access_result_type lookups_due[$];
   stim_row_type      directed_rows[$];

   int error_count = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;

   lru_page_replacement dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page          (req_page),
      .req_start_of_run  (req_start_of_run),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_hit           (rsp_hit),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_count   (rsp_fault_count),
      .rsp_access_count  (rsp_access_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs on either channel.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_CAP) begin
         $display("status: fail");
         $finish;
      end
   end

   // Empty the frame table and zero both counters, as at the start of a run.
   function automatic void clear_frames();
      for (int i = 0; i < FRAMES; i++) begin
         tbl_page[i]  = '0;
         tbl_valid[i] = 1'b0;
         tbl_rank[i]  = '0;
      end
      tbl_filled   = '0;
      run_faults   = '0;
      run_accesses = '0;
   endfunction

   // Apply one access to the private frame table and return what the block must report.
   // Rank 0 is the most recent frame; the oldest occupied frame has the largest rank.
   function automatic access_result_type lru_lookup(input logic [PAGE_WIDTH-1:0] pg,
                                                    input logic st);
      access_result_type res;
      int active_frames;
      int found_at;
      int target;
      int oldest;
      int age_limit;
      res = '0;
      if (st) begin
         clear_frames();
      end
      // Zero frames behaves as one, anything above the built size as the built size.
      active_frames = int'(frame_count_reg);
      if (active_frames < 1) begin
         active_frames = 1;
      end
      if (active_frames > FRAMES) begin
         active_frames = FRAMES;
      end
      found_at = -1;
      for (int i = 0; i < FRAMES; i++) begin
         if (found_at < 0 && tbl_valid[i] && tbl_page[i] == pg) begin
            found_at = i;
         end
      end
      if (found_at >= 0) begin
         // A hit only ages the frames that were newer than the one touched.
         target    = found_at;
         age_limit = int'(tbl_rank[target]);
         res.hit   = 1'b1;
      end else if (int'(tbl_filled) < active_frames) begin
         // Free frames are filled in order, even after the frame count was raised.
         target            = int'(tbl_filled);
         tbl_valid[target] = 1'b1;
         tbl_page[target]  = pg;
         tbl_rank[target]  = '0;
         tbl_filled        = tbl_filled + 1'b1;
         age_limit         = FRAMES;
      end else begin
         // Evict the oldest occupied frame, the lowest index on a tie. After the
         // frame count was lowered this still searches every occupied frame.
         oldest = -1;
         target = 0;
         for (int i = 0; i < FRAMES; i++) begin
            if (tbl_valid[i] && int'(tbl_rank[i]) > oldest) begin
               oldest = int'(tbl_rank[i]);
               target = i;
            end
         end
         res.evicted_valid = 1'b1;
         res.evicted_page  = tbl_page[target];
         tbl_page[target]  = pg;
         age_limit         = FRAMES;
      end
      for (int i = 0; i < FRAMES; i++) begin
         if (tbl_valid[i] && i != target && int'(tbl_rank[i]) < age_limit) begin
            tbl_rank[i] = tbl_rank[i] + 1'b1;
         end
      end
      tbl_rank[target] = '0;
      // Both counters stick at their maximum.
      if (!res.hit && run_faults != lru_pkg::COUNT_MAX) begin
         run_faults = run_faults + 1'b1;
      end
      if (run_accesses != lru_pkg::COUNT_MAX) begin
         run_accesses = run_accesses + 1'b1;
      end
      res.frame_index  = target[FRAME_INDEX_WIDTH-1:0];
      res.fault_count  = run_faults;
      res.access_count = run_accesses;
      return res;
   endfunction

   // Build one line of the directed table and append it.
   function automatic void add_row(input int csr_value, input int pg, input bit st,
                                   input bit typed, input bit hit, input int frame,
                                   input bit ev_valid, input int ev_page,
                                   input int faults, input int accesses);
      stim_row_type r;
      r.csr_value              = csr_value;
      r.page                   = pg[PAGE_WIDTH-1:0];
      r.start                  = st;
      r.typed                  = typed;
      r.outcome.hit            = hit;
      r.outcome.frame_index    = frame[FRAME_INDEX_WIDTH-1:0];
      r.outcome.evicted_valid  = ev_valid;
      r.outcome.evicted_page   = ev_page[PAGE_WIDTH-1:0];
      r.outcome.fault_count    = faults[COUNT_WIDTH-1:0];
      r.outcome.access_count   = accesses[COUNT_WIDTH-1:0];
      directed_rows.insert(directed_rows.size(), r);
   endfunction

   task automatic report_field(input string name, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Offer one access beat. Random gaps come first; once valid rises it stays high
   // with the same payload until the block takes the beat. The expectation is queued
   // at the accepting edge, which is always ahead of the matching result.
   task automatic send_access(input logic [PAGE_WIDTH-1:0] pg, input logic st,
                              input bit typed = 1'b0,
                              input access_result_type typed_outcome = '0);
      access_result_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_page         <= pg;
      req_start_of_run <= st;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predicted = lru_lookup(pg, st);
      lookups_due.insert(lookups_due.size(), typed ? typed_outcome : predicted);
   endtask

   // Stop offering beats and wait until the block has returned everything and the
   // pipeline is truly idle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (lookups_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic write_frame_count(input int value);
      drain_results();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value[FRAME_COUNT_WIDTH-1:0];
      @(posedge clock);
      csr_wr_en       <= 1'b0;
      frame_count_reg  = value[FRAME_COUNT_WIDTH-1:0];
   endtask

   // Result side: check every beat the block hands over, then choose whether to be
   // ready on the next edge. A long hold-off, when requested, overrides the random stalls.
   initial begin
      access_result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (lookups_due.size() == 0) begin
               $display("%0t: result beat with no access outstanding, actual frame %0d",
                        $time, rsp_frame_index);
               error_count++;
            end else begin
               want = lookups_due.pop_front();
               report_field("hit", want.hit, rsp_hit);
               report_field("frame_index", want.frame_index, rsp_frame_index);
               report_field("evicted_valid", want.evicted_valid, rsp_evicted_valid);
               report_field("evicted_page", want.evicted_page, rsp_evicted_page);
               report_field("fault_count", want.fault_count, rsp_fault_count);
               report_field("access_count", want.access_count, rsp_access_count);
            end
         end
         if (hold_left > 0) begin
            rsp_ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   initial begin
      int csr_plan[16];
      int idle_plan[4];
      int stall_plan[4];
      int plan_pos;
      int ws_base;
      int ws_span;
      logic [PAGE_WIDTH-1:0] pg;
      stim_row_type r;

      csr_plan   = '{16, 1, 31, 0, 5, 2, 17, 12, 3, 8, 16, 1, 9, 31, 4, 6};
      idle_plan  = '{0, 76, 0, 23};
      stall_plan = '{0, 0, 76, 23};

      frame_count_reg = lru_pkg::FRAME_COUNT_RESET;
      clear_frames();

      // Directed table. The first rows run with the reset frame count of four:
      // fill, hit, fill to full, evict the oldest page, then hit the page just brought in.
      add_row(NO_WRITE, 0,   1, 1, 0, 0, 0, 0,   1, 1);
      add_row(NO_WRITE, 255, 0, 1, 0, 1, 0, 0,   2, 2);
      add_row(NO_WRITE, 0,   0, 1, 1, 0, 0, 0,   2, 3);
      add_row(NO_WRITE, 7,   0, 1, 0, 2, 0, 0,   3, 4);
      add_row(NO_WRITE, 9,   0, 1, 0, 3, 0, 0,   4, 5);
      add_row(NO_WRITE, 11,  0, 1, 0, 1, 1, 255, 5, 6);
      add_row(NO_WRITE, 11,  0, 1, 1, 1, 0, 0,   5, 7);
      // A frame count of zero acts as a single frame.
      add_row(0,        5,   1, 1, 0, 0, 0, 0,   1, 1);
      add_row(NO_WRITE, 6,   0, 1, 0, 0, 1, 5,   2, 2);
      add_row(NO_WRITE, 6,   0, 1, 1, 0, 0, 0,   2, 3);
      // Raised above the built size mid-run: free frames fill again first.
      add_row(31,       128, 0, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 6,   0, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 64,  0, 0, 0, 0, 0, 0,   0, 0);
      // Lowered mid-run: resident pages still hit and misses evict among all of them.
      add_row(2,        200, 0, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 64,  0, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 6,   0, 0, 0, 0, 0, 0,   0, 0);
      add_row(16,       1,   1, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 2,   0, 0, 0, 0, 0, 0,   0, 0);
      add_row(NO_WRITE, 1,   0, 0, 0, 0, 0, 0,   0, 0);
      add_row(17,       3,   0, 0, 0, 0, 0, 0,   0, 0);
      add_row(1,        170, 1, 1, 0, 0, 0, 0,   1, 1);
      add_row(NO_WRITE, 85,  0, 1, 0, 0, 1, 170, 2, 2);

      // Synchronous reset, applied exactly once.
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.csr_value != NO_WRITE) begin
            write_frame_count(r.csr_value);
         end
         send_access(r.page, r.start, r.typed, r.outcome);
      end

      // Random part. Most pages come from a small working set of 2 to 21 pages,
      // which makes hits, fills and evictions all common; the rest span the whole range.
      plan_pos = 0;
      ws_base  = 0;
      ws_span  = 4;
      for (int ph = 0; ph < 4; ph++) begin
         send_idle_pct  = idle_plan[ph];
         recv_stall_pct = stall_plan[ph];
         for (int n = 0; n < PHASE_BEATS; n++) begin
            if (n % CSR_EVERY == 0) begin
               write_frame_count(csr_plan[plan_pos]);
               plan_pos = (plan_pos + 1) % 16;
               ws_base  = $urandom_range(255);
               ws_span  = $urandom_range(20, 1);
            end
            // Long receiver hold-off while the sender keeps pushing, so the block
            // backs up and drops req_ready.
            if (ph == 0 && n == 100) begin
               hold_left = 300;
            end
            // Sender pause until every outstanding result is back.
            if (n == 200) begin
               drain_results();
            end
            if ($urandom_range(99) < 75) begin
               pg = PAGE_WIDTH'(ws_base + $urandom_range(ws_span));
            end else begin
               pg = PAGE_WIDTH'($urandom_range(255));
            end
            send_access(pg, $urandom_range(99) < 3);
         end
      end

      // Wind down: stop offering beats, wait for the last results, then wait on
      // so that any extra beat from the block is caught.
      req_valid <= 1'b0;
      while (lookups_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
